### rtl/mbpns_pkg.sv
// shared types and constants for the midi byte parser with key stack
package mbpns_pkg;

    localparam int KEY_W  = 7;
    localparam int BYTE_W = 8;

    // status nibbles that are acted on
    localparam logic [3:0] NIB_NOTE_ON = 4'h9;
    localparam logic [3:0] NIB_CTRL    = 4'hB;
    localparam logic [3:0] NIB_BEND    = 4'hE;

    // controller numbers
    localparam logic [KEY_W-1:0] CC_GLIDE     = 7'd1;
    localparam logic [KEY_W-1:0] CC_VIB_SCALE = 7'd2;
    localparam logic [KEY_W-1:0] CC_ARP       = 7'd7;

    localparam logic [KEY_W-1:0] ARP_MAX     = 7'd127;
    localparam logic [13:0]      BEND_CENTRE = 14'd8192;

    // request to the key stack sequencer
    typedef struct packed {
        logic             valid;
        logic             push;   // 1 push, 0 remove
        logic [KEY_W-1:0] key;
    } stack_cmd_t;

    // status back from the key stack sequencer
    typedef struct packed {
        logic             done;
        logic             held;
        logic [KEY_W-1:0] top;
    } stack_stat_t;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]       pad;
        logic [13:0]      bend_value;
        logic [KEY_W-1:0] vibrato_scale;
        logic [KEY_W-1:0] vibrato_depth;
        logic             arp_on;
        logic [KEY_W-1:0] arp_rate;
        logic [KEY_W-1:0] glide_amount;
        logic             gate_on;
        logic [KEY_W-1:0] top_note;
    } result_t;

endpackage

### rtl/midi_byte_parser_note_stack.sv
// midi byte parser with a newest-key-first note stack, top level
//
// channel   dir  width  contents
// s_*       in   8      one raw midi byte per request
// m_*       out  56     one result per byte: parser and key stack state after it
//
// status bytes, first data bytes and pairs that leave the stack alone go straight to
// T_EMIT: the result register is loaded there once the output is free, then T_IDLE
// a note pair walks the stack memory one entry per cycle: a search over the held keys,
// then, where needed, a shift down on push or up on removal; the hand-off passes through
// cmd_reg, the sequencer and T_WAIT; a byte takes longest with a full stack
// a new byte is taken while the previous result still waits in the output register
// rst_n clears the parser, the settings (bend returns to its centre) and the fill count; no clearing pass is needed
// a stalled output holds its result and blocks the next result, and with it any later byte
module midi_byte_parser_note_stack
    import mbpns_pkg::*;
#(
    parameter int STACK_DEPTH = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // midi_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // top_note[6:0], gate_on[7], glide_amount[14:8],
                                   // arp_rate[21:15], arp_on[22], vibrato_depth[29:23],
                                   // vibrato_scale[36:30], bend_value[50:37], zeros above
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_WAIT,
        T_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic             pending_reg, pending_next;     // first data byte seen
    logic [3:0]       nibble_reg, nibble_next;
    logic [KEY_W-1:0] first_reg, first_next;
    logic [KEY_W-1:0] glide_reg, glide_next;
    logic [KEY_W-1:0] arp_rate_reg, arp_rate_next;
    logic             arp_on_reg, arp_on_next;
    logic [KEY_W-1:0] vib_depth_reg, vib_depth_next;
    logic [KEY_W-1:0] vib_scale_reg, vib_scale_next;
    logic [13:0]      bend_reg, bend_next;
    logic [KEY_W-1:0] last_note_reg, last_note_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    stack_cmd_t       cmd_reg, cmd_next;

    stack_stat_t      stat;
    logic             accept;
    logic [KEY_W-1:0] data_byte;

    mbpns_stack_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_reg),
        .stat  (stat)
    );

    assign s_tready  = (state_reg == T_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign data_byte = s_tdata[KEY_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        nibble_next    = nibble_reg;
        first_next     = first_reg;
        glide_next     = glide_reg;
        arp_rate_next  = arp_rate_reg;
        arp_on_next    = arp_on_reg;
        vib_depth_next = vib_depth_reg;
        vib_scale_next = vib_scale_reg;
        bend_next      = bend_reg;
        last_note_next = last_note_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        cmd_next       = '0;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_EMIT;
                    if (s_tdata[7])
                    begin
                        // status byte: keep the message type, restart the pair
                        nibble_next  = s_tdata[7:4];
                        pending_next = 1'b0;
                    end
                    else if (!pending_reg)
                    begin
                        first_next   = data_byte;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        case (nibble_reg)
                            NIB_NOTE_ON:
                            begin
                                cmd_next.valid = 1'b1;
                                cmd_next.key   = first_reg;
                                state_next     = T_WAIT;
                                if (data_byte != '0)
                                begin
                                    cmd_next.push  = 1'b1;
                                    vib_depth_next = data_byte;
                                end
                                else
                                begin
                                    // zero velocity releases the key
                                    cmd_next.push = 1'b0;
                                end
                            end
                            NIB_CTRL:
                            begin
                                if (first_reg == CC_GLIDE)
                                begin
                                    glide_next = data_byte;
                                end
                                if (first_reg == CC_ARP)
                                begin
                                    arp_rate_next = ARP_MAX - data_byte;
                                    arp_on_next   = (data_byte != '0);
                                end
                                if (first_reg == CC_VIB_SCALE)
                                begin
                                    vib_scale_next = data_byte;
                                end
                            end
                            NIB_BEND:
                            begin
                                bend_next = {data_byte, first_reg};
                            end
                            default:
                            begin
                                // note-off and others: pair consumed, no effect
                            end
                        endcase
                    end
                end
            end

            T_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = T_EMIT;
                end
            end

            T_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next.pad           = '0;
                    out_next.top_note      = stat.held ? stat.top : last_note_reg;
                    out_next.gate_on       = stat.held;
                    out_next.glide_amount  = glide_reg;
                    out_next.arp_rate      = arp_rate_reg;
                    out_next.arp_on        = arp_on_reg;
                    out_next.vibrato_depth = vib_depth_reg;
                    out_next.vibrato_scale = vib_scale_reg;
                    out_next.bend_value    = bend_reg;
                    if (stat.held)
                    begin
                        last_note_next = stat.top;
                    end
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pending_reg   <= 1'b0;
            nibble_reg    <= '0;
            first_reg     <= '0;
            glide_reg     <= '0;
            arp_rate_reg  <= '0;
            arp_on_reg    <= 1'b0;
            vib_depth_reg <= '0;
            vib_scale_reg <= '0;
            bend_reg      <= BEND_CENTRE;
            last_note_reg <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            nibble_reg    <= nibble_next;
            first_reg     <= first_next;
            glide_reg     <= glide_next;
            arp_rate_reg  <= arp_rate_next;
            arp_on_reg    <= arp_on_next;
            vib_depth_reg <= vib_depth_next;
            vib_scale_reg <= vib_scale_next;
            bend_reg      <= bend_next;
            last_note_reg <= last_note_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

### rtl/mbpns_key_ram.sv
// key stack storage, one write and one registered read port
module mbpns_key_ram
    import mbpns_pkg::*;
#(
    parameter int STACK_DEPTH = 20
)
(
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
    input  logic [KEY_W-1:0]               wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
    output logic [KEY_W-1:0]               rd_data
);

    logic [KEY_W-1:0] mem [STACK_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/mbpns_stack_ctrl.sv
// key stack sequencer: search, shift down on push, close the gap on removal
module mbpns_stack_ctrl
    import mbpns_pkg::*;
#(
    parameter int STACK_DEPTH = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  stack_cmd_t  cmd,
    output stack_stat_t stat
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_DN,
        ST_SHIFT_UP
    } state_t;

    state_t           state_reg, state_next;
    logic             push_reg, push_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [AW-1:0]    chk_addr_reg, chk_addr_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic [KEY_W-1:0] top_reg, top_next;
    logic             done_reg, done_next;

    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [KEY_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [KEY_W-1:0] ram_rd_data;
    logic [CW-1:0]    scan_dec;
    logic             hit;

    mbpns_key_ram #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign scan_dec = scan_reg - CW'(1);
    assign hit      = chk_valid_reg && (ram_rd_data == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        push_next      = push_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        wr_pend_next   = wr_pend_reg;
        wr_addr_next   = wr_addr_reg;
        top_next       = top_reg;
        done_next      = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    key_next       = cmd.key;
                    push_next      = cmd.push;
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    wr_pend_next   = 1'b0;
                    state_next     = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (hit)
                begin
                    chk_valid_next = 1'b0;
                    if (push_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_next  = CW'(chk_addr_reg) + CW'(1);
                        state_next = ST_SHIFT_UP;
                    end
                end
                else if (scan_reg < count_reg)
                begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = scan_reg[AW-1:0];
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_reg[AW-1:0];
                    scan_next      = scan_reg + CW'(1);
                end
                else
                begin
                    // key not held
                    chk_valid_next = 1'b0;
                    if (push_reg)
                    begin
                        scan_next  = (count_reg == DEPTH_C) ? (DEPTH_C - CW'(1)) : count_reg;
                        state_next = ST_SHIFT_DN;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SHIFT_DN:
            begin
                if (wr_pend_reg)
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_addr  = wr_addr_reg;
                    ram_wr_data  = ram_rd_data;
                    wr_pend_next = 1'b0;
                end
                if (scan_reg != '0)
                begin
                    // move entry scan-1 to scan, oldest first
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = scan_dec[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = scan_reg[AW-1:0];
                    scan_next    = scan_dec;
                end
                else if (!wr_pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = '0;
                    ram_wr_data = key_reg;
                    count_next  = (count_reg == DEPTH_C) ? count_reg : count_reg + CW'(1);
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_SHIFT_UP:
            begin
                if (wr_pend_reg)
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_addr  = wr_addr_reg;
                    ram_wr_data  = ram_rd_data;
                    wr_pend_next = 1'b0;
                end
                if (scan_reg < count_reg)
                begin
                    // move entry scan up to scan-1
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = scan_reg[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = scan_dec[AW-1:0];
                    scan_next    = scan_reg + CW'(1);
                end
                else if (!wr_pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // mirror of the top entry
        if (ram_wr_en && (ram_wr_addr == '0))
        begin
            top_next = ram_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            done_reg      <= 1'b0;
            top_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            wr_pend_reg   <= wr_pend_next;
            done_reg      <= done_next;
            top_reg       <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        push_reg     <= push_next;
        key_reg      <= key_next;
        scan_reg     <= scan_next;
        chk_addr_reg <= chk_addr_next;
        wr_addr_reg  <= wr_addr_next;
    end

    assign stat.done = done_reg;
    assign stat.held = (count_reg != '0);
    assign stat.top  = top_reg;

endmodule

### verif/tb_midi_byte_parser_note_stack.sv
// testbench for the midi byte parser with newest-key-first note stack
`timescale 1ns / 100ps

module tb_midi_byte_parser_note_stack;
    import mbpns_pkg::*;

    localparam int          STACK_DEPTH  = 20;
    localparam int          RANDOM_BYTES = 1150;
    localparam logic [7:0]  KEY_EMPTY    = 8'hFF;
    // worst case per byte is a full search and shift of the stack memory
    localparam int          SETTLE_CYCLES = 2 * STACK_DEPTH + 16;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // midi_byte[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;            // top_note, gate_on, glide_amount, arp_rate, arp_on,
                                     // vibrato_depth, vibrato_scale, bend_value, zeros above
    result_t     seen_res;

    assign seen_res = m_tdata;

    midi_byte_parser_note_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock, reset held low at the start and then released for good
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // predicted synth state: parser, key stack and controller settings
    // ------------------------------------------------------------------
    logic             pair_half;      // first data byte of a pair already taken
    logic [3:0]       cur_nibble;     // status high nibble, channel dropped
    logic [KEY_W-1:0] first_data;
    logic [7:0]       keys [STACK_DEPTH];   // newest key in slot 0, KEY_EMPTY marks a hole
    logic [KEY_W-1:0] sounded_key;    // last key seen on top of the stack
    logic [KEY_W-1:0] glide;
    logic [KEY_W-1:0] arp_rate_q;
    logic             arp_en;
    logic [KEY_W-1:0] vib_depth;
    logic [KEY_W-1:0] vib_scale;
    logic [13:0]      bend;

    // one midi byte in, state visible after it out
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        bit      found;
        if (b[7])
        begin
            // any status byte, system ones too, restarts the data pair
            cur_nibble = b[7:4];
            pair_half  = 1'b0;
        end
        else if (!pair_half)
        begin
            first_data = b[6:0];
            pair_half  = 1'b1;
        end
        else
        begin
            pair_half = 1'b0;
            case (cur_nibble)
                NIB_NOTE_ON:
                begin
                    if (b[6:0] != '0)
                    begin
                        // push unless already held, oldest falls off the bottom
                        found = 1'b0;
                        for (int i = 0; i < STACK_DEPTH; i++)
                            if (keys[i] == {1'b0, first_data})
                                found = 1'b1;
                        if (!found)
                        begin
                            for (int i = STACK_DEPTH - 1; i > 0; i--)
                                keys[i] = keys[i - 1];
                            keys[0] = {1'b0, first_data};
                        end
                        vib_depth = b[6:0];
                    end
                    else
                    begin
                        // zero velocity releases the key, a single bubble pass closes the gap
                        for (int i = 0; i < STACK_DEPTH; i++)
                            if (keys[i] == {1'b0, first_data})
                                keys[i] = KEY_EMPTY;
                        for (int i = 0; i < STACK_DEPTH - 1; i++)
                            if (keys[i] == KEY_EMPTY)
                            begin
                                keys[i]     = keys[i + 1];
                                keys[i + 1] = KEY_EMPTY;
                            end
                    end
                end
                NIB_CTRL:
                begin
                    if (first_data == CC_GLIDE)
                        glide = b[6:0];
                    if (first_data == CC_ARP)
                    begin
                        arp_rate_q = ARP_MAX - b[6:0];
                        arp_en     = (b[6:0] != '0);
                    end
                    if (first_data == CC_VIB_SCALE)
                        vib_scale = b[6:0];
                end
                NIB_BEND:
                    bend = {b[6:0], first_data};
                default:
                    ;   // note-off and everything else: pair consumed, nothing else
            endcase
        end

        if (!keys[0][7])
            sounded_key = keys[0][6:0];

        r               = '0;
        r.top_note      = sounded_key;
        r.gate_on       = !keys[0][7];
        r.glide_amount  = glide;
        r.arp_rate      = arp_rate_q;
        r.arp_on        = arp_en;
        r.vibrato_depth = vib_depth;
        r.vibrato_scale = vib_scale;
        r.bend_value    = bend;
        return r;
    endfunction

    function automatic string show_state(input result_t r);
        return $sformatf({"top %0d gate %0b glide %0d rate %0d arp %0b ",
                          "depth %0d scale %0d bend %0d pad %0h"},
                         r.top_note, r.gate_on, r.glide_amount, r.arp_rate, r.arp_on,
                         r.vibrato_depth, r.vibrato_scale, r.bend_value, r.pad);
    endfunction

    // ------------------------------------------------------------------
    // stimulus store: directed rows first, then random messages
    // ------------------------------------------------------------------
    logic [7:0] midi_q [$];
    bit         row_known [$];    // directed row carries a hand-typed expectation
    result_t    row_exp [$];
    result_t    predicted_q [$];  // synth states still owed by the block

    int mismatch_count = 0;
    int result_count   = 0;

    task automatic add_row(input logic [7:0] b, input bit known,
                           input logic [6:0] top, input bit gate,
                           input logic [6:0] glide_v, input logic [6:0] rate_v,
                           input bit arp_v, input logic [6:0] depth_v,
                           input logic [6:0] scale_v, input logic [13:0] bend_v);
        result_t r;
        r               = '0;
        r.top_note      = top;
        r.gate_on       = gate;
        r.glide_amount  = glide_v;
        r.arp_rate      = rate_v;
        r.arp_on        = arp_v;
        r.vibrato_depth = depth_v;
        r.vibrato_scale = scale_v;
        r.bend_value    = bend_v;
        midi_q.push_back(b);
        row_known.push_back(known);
        row_exp.push_back(r);
    endtask

    // send requests lo..hi-1 in bursts of random length with random gaps
    task automatic send_range(input int lo, input int hi);
        int      idx;
        int      burst;
        int      gap;
        result_t r;
        idx = lo;
        while (idx < hi)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            while (burst > 0 && idx < hi)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= midi_q[idx];
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
                // request taken at this edge
                r = parse_byte(midi_q[idx]);
                if (idx < row_known.size() && row_known[idx])
                    r = row_exp[idx];
                predicted_q.push_back(r);
                idx++;
                burst--;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(8, 20);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (predicted_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] gen_status;
        logic [7:0] key;
        logic [7:0] ctrl;
        logic [7:0] val;
        logic [3:0] chan;
        int         pick;
        int         key_base;
        int         n_rows;
        int         half;

        // predictor follows the block's reset
        pair_half   = 1'b0;
        cur_nibble  = '0;
        first_data  = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
            keys[i] = KEY_EMPTY;
        sounded_key = '0;
        glide       = '0;
        arp_rate_q  = '0;
        arp_en      = 1'b0;
        vib_depth   = '0;
        vib_scale   = '0;
        bend        = BEND_CENTRE;

        // directed rows: byte, typed?, top gate glide rate arp depth scale bend
        add_row(8'h05, 1, 0, 0,   0,   0, 0, 0, 0,  8192); // data before any status
        add_row(8'h7F, 1, 0, 0,   0,   0, 0, 0, 0,  8192);
        add_row(8'hE0, 1, 0, 0,   0,   0, 0, 0, 0,  8192); // pitch bend
        add_row(8'h00, 1, 0, 0,   0,   0, 0, 0, 0,  8192);
        add_row(8'h00, 1, 0, 0,   0,   0, 0, 0, 0,     0); // bend floor
        add_row(8'h7F, 1, 0, 0,   0,   0, 0, 0, 0,     0);
        add_row(8'h7F, 1, 0, 0,   0,   0, 0, 0, 0, 16383); // bend ceiling
        add_row(8'hB3, 1, 0, 0,   0,   0, 0, 0, 0, 16383); // control change, channel ignored
        add_row(8'h01, 1, 0, 0,   0,   0, 0, 0, 0, 16383);
        add_row(8'h7F, 1, 0, 0, 127,   0, 0, 0, 0, 16383); // glide to full
        add_row(8'h07, 1, 0, 0, 127,   0, 0, 0, 0, 16383); // running status
        add_row(8'h00, 1, 0, 0, 127, 127, 0, 0, 0, 16383); // arpeggio off, slowest rate
        add_row(8'h02, 0, 0, 0,   0,   0, 0, 0, 0,     0);
        add_row(8'h55, 0, 0, 0,   0,   0, 0, 0, 0,     0); // vibrato scale
        add_row(8'h9F, 0, 0, 0,   0,   0, 0, 0, 0,     0); // note-on
        add_row(8'h00, 0, 0, 0,   0,   0, 0, 0, 0,     0);
        add_row(8'h7F, 0, 0, 0,   0,   0, 0, 0, 0,     0); // lowest key, loudest velocity
        add_row(8'h7F, 0, 0, 0,   0,   0, 0, 0, 0,     0);
        add_row(8'h01, 0, 0, 0,   0,   0, 0, 0, 0,     0); // highest key, quietest velocity
        add_row(8'h7F, 0, 0, 0,   0,   0, 0, 0, 0,     0);
        add_row(8'h00, 0, 0, 0,   0,   0, 0, 0, 0,     0); // release the top key
        add_row(8'h40, 0, 0, 0,   0,   0, 0, 0, 0,     0);
        add_row(8'h00, 0, 0, 0,   0,   0, 0, 0, 0,     0); // release a key not held
        add_row(8'hFF, 0, 0, 0,   0,   0, 0, 0, 0,     0); // system byte stores nibble f
        n_rows = midi_q.size();

        // random messages: mostly well-formed with running status, some noise
        gen_status = 8'hFF;
        key_base   = 40;
        while (midi_q.size() < n_rows + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            chan = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 63) == 0)
                key_base = $urandom_range(0, 100);
            if (pick < 48)
            begin
                // note-on from a pool wider than the stack so it overflows
                if (gen_status[7:4] != NIB_NOTE_ON || $urandom_range(0, 3) == 0)
                begin
                    gen_status = {NIB_NOTE_ON, chan};
                    midi_q.push_back(gen_status);
                end
                key = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 127))
                                                  : 8'(key_base + $urandom_range(0, 26));
                val = ($urandom_range(0, 99) < 62) ? 8'($urandom_range(1, 127)) : 8'd0;
                midi_q.push_back(key);
                midi_q.push_back(val);
            end
            else if (pick < 63)
            begin
                if (gen_status[7:4] != NIB_CTRL || $urandom_range(0, 2) == 0)
                begin
                    gen_status = {NIB_CTRL, chan};
                    midi_q.push_back(gen_status);
                end
                case ($urandom_range(0, 3))
                    0:       ctrl = {1'b0, CC_GLIDE};
                    1:       ctrl = {1'b0, CC_VIB_SCALE};
                    2:       ctrl = {1'b0, CC_ARP};
                    default: ctrl = 8'($urandom_range(0, 127));
                endcase
                case ($urandom_range(0, 4))
                    0:       val = 8'd0;
                    1:       val = 8'd127;
                    default: val = 8'($urandom_range(0, 127));
                endcase
                midi_q.push_back(ctrl);
                midi_q.push_back(val);
            end
            else if (pick < 72)
            begin
                if (gen_status[7:4] != NIB_BEND || $urandom_range(0, 1) == 0)
                begin
                    gen_status = {NIB_BEND, chan};
                    midi_q.push_back(gen_status);
                end
                midi_q.push_back(8'($urandom_range(0, 127)));
                midi_q.push_back(8'($urandom_range(0, 127)));
            end
            else if (pick < 79)
            begin
                // note-off is parsed but has no effect
                gen_status = {4'h8, chan};
                midi_q.push_back(gen_status);
                midi_q.push_back(8'(key_base + $urandom_range(0, 26)));
                midi_q.push_back(8'($urandom_range(0, 127)));
            end
            else if (pick < 86)
            begin
                // other channel messages and system bytes with a few data bytes
                case ($urandom_range(0, 3))
                    0:       gen_status = {4'hA, chan};
                    1:       gen_status = {4'hC, chan};
                    2:       gen_status = {4'hD, chan};
                    default: gen_status = {4'hF, chan};
                endcase
                midi_q.push_back(gen_status);
                repeat ($urandom_range(0, 2))
                    midi_q.push_back(8'($urandom_range(0, 127)));
            end
            else if (pick < 93)
            begin
                // message cut short after its first data byte
                case ($urandom_range(0, 2))
                    0:       gen_status = {NIB_NOTE_ON, chan};
                    1:       gen_status = {NIB_CTRL, chan};
                    default: gen_status = {NIB_BEND, chan};
                endcase
                midi_q.push_back(gen_status);
                midi_q.push_back(8'($urandom_range(0, 127)));
            end
            else
            begin
                val = 8'($urandom_range(0, 255));
                if (val[7])
                    gen_status = val;
                midi_q.push_back(val);
            end
        end
        half = n_rows + (midi_q.size() - n_rows) / 2;

        wait (rst_n === 1'b1);
        @(posedge clk);

        send_range(0, n_rows);
        // hold off until every owed state has come back
        wait_drained();
        send_range(n_rows, half);
        wait_drained();
        send_range(half, midi_q.size());
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && predicted_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: stall pattern of its own, stretches of full rate
    // ------------------------------------------------------------------
    initial
    begin
        int         mode;
        logic [7:0] pattern;
        wait (rst_n === 1'b1);
        pattern = 8'b1011_0010;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(8, 80))
            begin
                @(posedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= pattern[0];
                endcase
                pattern = {pattern[0], pattern[7:1]};
            end
        end
    end

    // each taken result against the oldest owed state, pad bits included
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (predicted_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing owed: %s",
                             result_count, show_state(seen_res));
            end
            else
            begin
                want = predicted_q.pop_front();
                if (seen_res.top_note      !== want.top_note      ||
                    seen_res.gate_on       !== want.gate_on       ||
                    seen_res.glide_amount  !== want.glide_amount  ||
                    seen_res.arp_rate      !== want.arp_rate      ||
                    seen_res.arp_on        !== want.arp_on        ||
                    seen_res.vibrato_depth !== want.vibrato_depth ||
                    seen_res.vibrato_scale !== want.vibrato_scale ||
                    seen_res.bend_value    !== want.bend_value    ||
                    seen_res.pad           !== want.pad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d mismatch\n  want %s\n  got  %s",
                                 result_count, show_state(want), show_state(seen_res));
                end
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
